/* rtl/mdas_pkg.sv */
// ----------------------------------------------------------------------------
// mdas_pkg
// Shared constants and types for the multidimensional array store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mdas_pkg;

  // Fixed field widths
  localparam int MAX_DIMS       = 3;
  localparam int COORD_BITS     = 16;
  localparam int DATA_BITS      = 32;
  localparam int CFG_INDEX_BITS = 3;
  localparam int DIM_IDX_BITS   = 2;

  // Queue depths between the parts
  localparam int CMDQ_DEPTH = 8;
  localparam int OUTQ_DEPTH = 4;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef coord_t [MAX_DIMS-1:0] coord_vec_t;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_READ  = 1'b1
  } op_t;

  // Geometry unit status seen by the front end
  typedef struct packed {
    logic busy;
    logic ok;
  } geom_status_t;

  // Back end status seen by the front end
  typedef struct packed {
    logic clearing;
    logic cmd_pop;
  } back_status_t;

endpackage

/* rtl/mdas_fifo.sv */
// ----------------------------------------------------------------------------
// mdas_fifo
// Small register queue with head data shown while not empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdas_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int PW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty,
  output logic             full,
  output logic [CW-1:0]    count
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;

  // Pointer and occupancy update
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];
  assign empty   = (count_r == '0);
  assign full    = (count_r == CW'(DEPTH));
  assign count   = count_r;

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
    else $error("mdas_fifo: push into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
    else $error("mdas_fifo: pop from an empty queue");
`endif

endmodule

/* rtl/mdas_geom.sv */
// ----------------------------------------------------------------------------
// mdas_geom
// Bound registers and stride computation, one dimension per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdas_geom #(
  parameter int DIMS     = 3,
  parameter int CAPACITY = 4096,
  localparam int STRIDE_W = $clog2(CAPACITY + 1)
) (
  input  logic                                              clk,
  input  logic                                              rst_n,
  input  logic                                              cfg_valid,
  input  logic [mdas_pkg::CFG_INDEX_BITS-1:0]               cfg_index,
  input  mdas_pkg::coord_t                                  cfg_data,
  output mdas_pkg::coord_vec_t                              lower,
  output mdas_pkg::coord_vec_t                              upper,
  output logic [mdas_pkg::MAX_DIMS-1:0][STRIDE_W-1:0]       stride,
  output mdas_pkg::geom_status_t                            status
);

  import mdas_pkg::*;

  typedef enum logic [1:0] {
    GEOM_IDLE = 2'b01,
    GEOM_CALC = 2'b10
  } geom_state_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_LOWER_0 = 3'd0,
    REG_UPPER_0 = 3'd1,
    REG_LOWER_1 = 3'd2,
    REG_UPPER_1 = 3'd3,
    REG_LOWER_2 = 3'd4,
    REG_UPPER_2 = 3'd5
  } cfg_reg_t;

  localparam int EXT_W  = COORD_BITS + 2;
  localparam int PROD_W = 2 * STRIDE_W;
  localparam logic signed [EXT_W-1:0]    CAP_S    = EXT_W'(CAPACITY);
  localparam logic [PROD_W-1:0]          CAP_P    = PROD_W'(CAPACITY);
  localparam logic [DIM_IDX_BITS-1:0]    LAST_DIM = DIM_IDX_BITS'(DIMS - 1);
  localparam coord_t                     UPPER_RESET = COORD_BITS'(15);

  geom_state_t                          state_r, state_nxt;
  coord_vec_t                           lower_r, lower_nxt;
  coord_vec_t                           upper_r, upper_nxt;
  logic [MAX_DIMS-1:0][STRIDE_W-1:0]    stride_r, stride_nxt;
  logic [STRIDE_W-1:0]                  run_r, run_nxt;
  logic [DIM_IDX_BITS-1:0]              dim_r, dim_nxt;
  logic                                 bad_r, bad_nxt;
  logic                                 ok_r, ok_nxt;
  coord_t                               lo_sel, hi_sel;
  logic signed [EXT_W-1:0]              ext_s;
  logic                                 ext_bad;
  logic [STRIDE_W-1:0]                  ext_u;
  logic [PROD_W-1:0]                    prod;
  logic                                 prod_bad;

  // Extent of the current dimension and running product
  always_comb begin
    lo_sel   = lower_r[dim_r];
    hi_sel   = upper_r[dim_r];
    ext_s    = $signed({{2{hi_sel[COORD_BITS-1]}}, hi_sel})
             - $signed({{2{lo_sel[COORD_BITS-1]}}, lo_sel})
             + $signed(EXT_W'(1));
    ext_bad  = (ext_s <= $signed(EXT_W'(0))) || (ext_s > CAP_S);
    ext_u    = ext_s[STRIDE_W-1:0];
    prod     = PROD_W'(run_r) * PROD_W'(ext_u);
    prod_bad = (prod > CAP_P);
  end

  // Register writes restart the stride walk from the fastest dimension
  always_comb begin
    state_nxt  = state_r;
    lower_nxt  = lower_r;
    upper_nxt  = upper_r;
    stride_nxt = stride_r;
    run_nxt    = run_r;
    dim_nxt    = dim_r;
    bad_nxt    = bad_r;
    ok_nxt     = ok_r;
    if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOWER_0: lower_nxt[0] = cfg_data;
        REG_UPPER_0: upper_nxt[0] = cfg_data;
        REG_LOWER_1: lower_nxt[1] = cfg_data;
        REG_UPPER_1: upper_nxt[1] = cfg_data;
        REG_LOWER_2: lower_nxt[2] = cfg_data;
        REG_UPPER_2: upper_nxt[2] = cfg_data;
        default: ;
      endcase
      state_nxt = GEOM_CALC;
      dim_nxt   = LAST_DIM;
      run_nxt   = STRIDE_W'(1);
      bad_nxt   = 1'b0;
    end else if (state_r == GEOM_CALC) begin
      stride_nxt[dim_r] = run_r;
      run_nxt           = prod[STRIDE_W-1:0];
      bad_nxt           = bad_r | ext_bad | prod_bad;
      if (dim_r == '0) begin
        state_nxt = GEOM_IDLE;
        ok_nxt    = !(bad_r | ext_bad | prod_bad);
      end else begin
        dim_nxt = dim_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= GEOM_CALC;
      lower_r <= '0;
      upper_r <= {MAX_DIMS{UPPER_RESET}};
      run_r   <= STRIDE_W'(1);
      dim_r   <= LAST_DIM;
      bad_r   <= 1'b0;
      ok_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      lower_r <= lower_nxt;
      upper_r <= upper_nxt;
      run_r   <= run_nxt;
      dim_r   <= dim_nxt;
      bad_r   <= bad_nxt;
      ok_r    <= ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    stride_r <= stride_nxt;
  end

  assign lower       = lower_r;
  assign upper       = upper_r;
  assign stride      = stride_r;
  assign status.busy = (state_r == GEOM_CALC);
  assign status.ok   = ok_r;

endmodule

/* rtl/mdas_front.sv */
// ----------------------------------------------------------------------------
// mdas_front
// Accepts transactions, checks bounds and forms the row-major offset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdas_front #(
  parameter int DIMS     = 3,
  parameter int CAPACITY = 4096,
  localparam int STRIDE_W = $clog2(CAPACITY + 1),
  localparam int AW       = $clog2(CAPACITY)
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  logic                                        in_push,
  output logic                                        in_full,
  input  logic                                        in_op,
  input  mdas_pkg::coord_vec_t                        in_coord,
  input  logic [mdas_pkg::DATA_BITS-1:0]              in_word,
  input  mdas_pkg::coord_vec_t                        lower,
  input  mdas_pkg::coord_vec_t                        upper,
  input  logic [mdas_pkg::MAX_DIMS-1:0][STRIDE_W-1:0] stride,
  input  mdas_pkg::geom_status_t                      geom,
  input  mdas_pkg::back_status_t                      back,
  output logic                                        cmd_push,
  output mdas_pkg::op_t                               cmd_op,
  output logic                                        cmd_fault,
  output logic [AW-1:0]                               cmd_off,
  output logic [mdas_pkg::DATA_BITS-1:0]              cmd_word
);

  import mdas_pkg::*;

  localparam int CW     = $clog2(CMDQ_DEPTH + 1);
  localparam int FULL_W = COORD_BITS + STRIDE_W;

  logic                          accept;
  logic [CW-1:0]                 credit_r, credit_nxt;
  logic                          s1_v_r, s2_v_r, s3_v_r;

  op_t                           s1_op_r, s2_op_r, s3_op_r;
  coord_vec_t                    s1_coord_r;
  logic [DATA_BITS-1:0]          s1_word_r, s2_word_r, s3_word_r;
  coord_vec_t                    s2_rel_r, rel_nxt;
  logic                          s2_fault_r, s3_fault_r, fault_nxt;
  logic [MAX_DIMS-1:0][AW-1:0]   s3_prod_r, prod_nxt;

  // Input handshake and command queue credits
  assign accept  = in_push && !in_full;
  assign in_full = geom.busy || back.clearing || (credit_r == '0);

  always_comb begin
    credit_nxt = credit_r - CW'(accept) + CW'(back.cmd_pop);
  end

  // Stage 2: per-dimension bound check, geometry check and relative index
  always_comb begin
    logic lane_ok;
    fault_nxt = !geom.ok;
    for (int d = 0; d < MAX_DIMS; d++) begin
      lane_ok = ($signed(s1_coord_r[d]) >= $signed(lower[d]))
             && ($signed(s1_coord_r[d]) <= $signed(upper[d]));
      rel_nxt[d] = (d < DIMS) ? (s1_coord_r[d] - lower[d]) : '0;
      if ((d < DIMS) && !lane_ok) begin
        fault_nxt = 1'b1;
      end
    end
  end

  // Stage 3: one product per dimension lane
  always_comb begin
    logic [FULL_W-1:0] full_p;
    for (int d = 0; d < MAX_DIMS; d++) begin
      full_p      = FULL_W'(s2_rel_r[d]) * FULL_W'(stride[d]);
      prod_nxt[d] = (d < DIMS) ? full_p[AW-1:0] : '0;
    end
  end

  // Offset sum feeding the command queue
  always_comb begin
    cmd_off = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      cmd_off = cmd_off + s3_prod_r[d];
    end
  end

  assign cmd_push  = s3_v_r;
  assign cmd_op    = s3_op_r;
  assign cmd_fault = s3_fault_r;
  assign cmd_word  = s3_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      credit_r <= CW'(CMDQ_DEPTH);
      s1_v_r   <= 1'b0;
      s2_v_r   <= 1'b0;
      s3_v_r   <= 1'b0;
    end else begin
      credit_r <= credit_nxt;
      s1_v_r   <= accept;
      s2_v_r   <= s1_v_r;
      s3_v_r   <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_t'(in_op);
      s1_coord_r <= in_coord;
      s1_word_r  <= in_word;
    end
    s2_op_r    <= s1_op_r;
    s2_word_r  <= s1_word_r;
    s2_rel_r   <= rel_nxt;
    s2_fault_r <= fault_nxt;
    s3_op_r    <= s2_op_r;
    s3_word_r  <= s2_word_r;
    s3_prod_r  <= prod_nxt;
    s3_fault_r <= s2_fault_r;
  end

`ifndef NO_ASSERTIONS
  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
      credit_r <= CW'(CMDQ_DEPTH))
    else $error("mdas_front: command credit above queue depth");
`endif

endmodule

/* rtl/mdas_back.sv */
// ----------------------------------------------------------------------------
// mdas_back
// Command queue, word store with clearing sweep, and result queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mdas_back #(
  parameter int CAPACITY  = 4096,
  parameter int WORD_BITS = 32,
  localparam int AW = $clog2(CAPACITY)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cmd_push,
  input  mdas_pkg::op_t                  cmd_op,
  input  logic                           cmd_fault,
  input  logic [AW-1:0]                  cmd_off,
  input  logic [mdas_pkg::DATA_BITS-1:0] cmd_word,
  output mdas_pkg::back_status_t         status,
  output logic                           out_empty,
  input  logic                           out_pop,
  output logic [mdas_pkg::DATA_BITS-1:0] out_read_word,
  output logic                           out_has_value,
  output logic                           out_out_of_range
);

  import mdas_pkg::*;

  typedef enum logic [1:0] {
    BACK_CLEAR = 2'b01,
    BACK_RUN   = 2'b10
  } back_state_t;

  localparam int CMD_W = 2 + AW + DATA_BITS;
  localparam int RES_W = DATA_BITS + 2;
  localparam int OCW   = $clog2(OUTQ_DEPTH + 1);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CAPACITY - 1);

  back_state_t           state_r, state_nxt;
  logic [AW-1:0]         clr_ptr_r, clr_ptr_nxt;
  logic [OCW-1:0]        ocredit_r, ocredit_nxt;

  logic [CMD_W-1:0]      q_data;
  logic                  q_empty;
  op_t                   q_op;
  logic                  q_fault;
  logic [AW-1:0]         q_off;
  logic [DATA_BITS-1:0]  q_word;
  logic                  issue;

  logic                  clearing;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr;
  logic [WORD_BITS-1:0]  mem_wdata;
  logic [WORD_BITS-1:0]  mem [CAPACITY];
  logic [WORD_BITS-1:0]  rdata_r;

  logic                  iss_v_r;
  op_t                   iss_op_r;
  logic                  iss_fault_r;

  logic                  res_read;
  logic [RES_W-1:0]      res_data, outq_data;
  logic                  pop_acc;
  logic [OCW-1:0]        outq_count;

  // Command queue between front and back
  mdas_fifo #(
    .WIDTH (CMD_W),
    .DEPTH (CMDQ_DEPTH)
  ) u_cmdq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (cmd_push),
    .wr_data ({cmd_op, cmd_fault, cmd_off, cmd_word}),
    .pop     (issue),
    .rd_data (q_data),
    .empty   (q_empty),
    .full    (),
    .count   ()
  );

  assign q_op    = op_t'(q_data[CMD_W-1]);
  assign q_fault = q_data[CMD_W-2];
  assign q_off   = q_data[DATA_BITS +: AW];
  assign q_word  = q_data[DATA_BITS-1:0];

  // Issue one command when a result slot is reserved
  assign clearing = (state_r == BACK_CLEAR);
  assign issue    = (state_r == BACK_RUN) && !q_empty && (ocredit_r != '0);

  // Clearing sweep after reset
  always_comb begin
    state_nxt   = state_r;
    clr_ptr_nxt = clr_ptr_r;
    case (state_r)
      BACK_CLEAR: begin
        clr_ptr_nxt = clr_ptr_r + 1'b1;
        if (clr_ptr_r == LAST_ADDR) begin
          state_nxt = BACK_RUN;
        end
      end
      BACK_RUN: ;
      default: state_nxt = BACK_CLEAR;
    endcase
  end

  // Store access
  assign mem_we    = clearing || (issue && (q_op == OP_WRITE) && !q_fault);
  assign mem_re    = issue && (q_op == OP_READ) && !q_fault;
  assign mem_waddr = clearing ? clr_ptr_r : q_off;
  assign mem_wdata = clearing ? '0 : WORD_BITS'(q_word);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_r <= mem[q_off];
    end
  end

  // Result formation
  always_comb begin
    res_read = (iss_op_r == OP_READ) && !iss_fault_r;
    res_data = {res_read ? DATA_BITS'(rdata_r) : {DATA_BITS{1'b0}},
                res_read && (rdata_r != '0),
                iss_fault_r};
  end

  assign pop_acc     = out_pop && !out_empty;
  assign ocredit_nxt = ocredit_r - OCW'(issue) + OCW'(pop_acc);

  mdas_fifo #(
    .WIDTH (RES_W),
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (iss_v_r),
    .wr_data (res_data),
    .pop     (pop_acc),
    .rd_data (outq_data),
    .empty   (out_empty),
    .full    (),
    .count   (outq_count)
  );

  assign out_read_word    = outq_data[RES_W-1:2];
  assign out_has_value    = outq_data[1];
  assign out_out_of_range = outq_data[0];

  assign status.clearing = clearing;
  assign status.cmd_pop  = issue;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= BACK_CLEAR;
      clr_ptr_r <= '0;
      ocredit_r <= OCW'(OUTQ_DEPTH);
      iss_v_r   <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      clr_ptr_r <= clr_ptr_nxt;
      ocredit_r <= ocredit_nxt;
      iss_v_r   <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      iss_op_r    <= q_op;
      iss_fault_r <= q_fault;
    end
  end

`ifndef NO_ASSERTIONS
  a_slot_balance: assert property (@(posedge clk) disable iff (!rst_n)
      (ocredit_r + OCW'(iss_v_r) + outq_count) == OCW'(OUTQ_DEPTH))
    else $error("mdas_back: result slot accounting lost a transaction");
`endif

endmodule

/* rtl/multidim_array_store_core.sv */
// ----------------------------------------------------------------------------
// multidim_array_store_core
// Throughput: one transaction per cycle while results are popped; set by the
//   credit loops of the 8-entry command queue and the 4-entry result queue.
// A configuration write holds in_full high for a stride step per dimension.
// Reset: rst_n synchronous, active low; then in_full stays high while the store
//   is cleared one word per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multidim_array_store_core #(
  parameter int DIMS      = 3,
  parameter int CAPACITY  = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  // input transactions
  input  logic                                       in_push,
  output logic                                       in_full,
  input  logic                                       in_op,
  input  logic signed [mdas_pkg::COORD_BITS-1:0]     in_coord_0,
  input  logic signed [mdas_pkg::COORD_BITS-1:0]     in_coord_1,
  input  logic signed [mdas_pkg::COORD_BITS-1:0]     in_coord_2,
  input  logic [mdas_pkg::DATA_BITS-1:0]             in_write_word,
  // result transactions
  output logic                                       out_empty,
  input  logic                                       out_pop,
  output logic [mdas_pkg::DATA_BITS-1:0]             out_read_word,
  output logic                                       out_has_value,
  output logic                                       out_out_of_range,
  // configuration writes
  input  logic                                       cfg_valid,
  output logic                                       cfg_ready,
  input  logic [mdas_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
  input  logic signed [mdas_pkg::COORD_BITS-1:0]     cfg_data
);

  import mdas_pkg::*;

  localparam int STRIDE_W = $clog2(CAPACITY + 1);
  localparam int AW       = $clog2(CAPACITY);

  coord_vec_t                         coord_vec;
  coord_vec_t                         lower, upper;
  logic [MAX_DIMS-1:0][STRIDE_W-1:0]  stride;
  geom_status_t                       geom_status;
  back_status_t                       back_status;

  logic                               cmd_push;
  op_t                                cmd_op;
  logic                               cmd_fault;
  logic [AW-1:0]                      cmd_off;
  logic [DATA_BITS-1:0]               cmd_word;

  assign coord_vec = {in_coord_2, in_coord_1, in_coord_0};
  assign cfg_ready = 1'b1;

  // Bounds and strides
  mdas_geom #(
    .DIMS     (DIMS),
    .CAPACITY (CAPACITY)
  ) u_geom (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lower     (lower),
    .upper     (upper),
    .stride    (stride),
    .status    (geom_status)
  );

  // Accept, check and locate
  mdas_front #(
    .DIMS     (DIMS),
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_op     (in_op),
    .in_coord  (coord_vec),
    .in_word   (in_write_word),
    .lower     (lower),
    .upper     (upper),
    .stride    (stride),
    .geom      (geom_status),
    .back      (back_status),
    .cmd_push  (cmd_push),
    .cmd_op    (cmd_op),
    .cmd_fault (cmd_fault),
    .cmd_off   (cmd_off),
    .cmd_word  (cmd_word)
  );

  // Store access and results
  mdas_back #(
    .CAPACITY  (CAPACITY),
    .WORD_BITS (WORD_BITS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd_push         (cmd_push),
    .cmd_op           (cmd_op),
    .cmd_fault        (cmd_fault),
    .cmd_off          (cmd_off),
    .cmd_word         (cmd_word),
    .status           (back_status),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_read_word    (out_read_word),
    .out_has_value    (out_has_value),
    .out_out_of_range (out_out_of_range)
  );

endmodule

/* bench/multidim_array_store_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multidim_array_store_core_tb
// Self-checking bench for the row-major 3-D word store. The bench keeps a
// model of the bounds registers and the word store and predicts every
// transaction as it is accepted. The result side is drained by its own process
// and compared against the oldest prediction. Directed corner tests come first,
// then random accesses over a series of geometries: reset, negative, extreme,
// over capacity, empty, single entry and random.
// ----------------------------------------------------------------------------

module multidim_array_store_core_tb;
  import mdas_pkg::*;

  localparam int DIMS           = 3;
  localparam int CAPACITY       = 4096;
  localparam int SETTLE_CYCLES  = 12;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int TIMEOUT_NS     = 400_000;

  // Bounds register map; indexes 6 and 7 hit no register
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_0 = 3'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_0 = 3'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_1 = 3'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_1 = 3'd3;
  localparam logic [CFG_INDEX_BITS-1:0] REG_LOWER_2 = 3'd4;
  localparam logic [CFG_INDEX_BITS-1:0] REG_UPPER_2 = 3'd5;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SPARE_7 = 3'd7;

  typedef logic signed [COORD_BITS-1:0] index_t;

  typedef struct {
    logic [DATA_BITS-1:0] read_word;
    logic                 has_value;
    logic                 out_of_range;
  } access_result_t;

  typedef struct {
    index_t c0;
    index_t c1;
    index_t c2;
  } position_t;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_push;
  logic                       in_full;
  logic                       in_op;
  index_t                     in_coord_0;
  index_t                     in_coord_1;
  index_t                     in_coord_2;
  logic [DATA_BITS-1:0]       in_write_word;
  logic                       out_empty;
  logic                       out_pop;
  logic [DATA_BITS-1:0]       out_read_word;
  logic                       out_has_value;
  logic                       out_out_of_range;
  logic                       cfg_valid;
  logic                       cfg_ready;
  logic [CFG_INDEX_BITS-1:0]  cfg_index;
  index_t                     cfg_data;

  // Model state: bounds, stored words, pending predictions
  int                         bound_lo [DIMS];
  int                         bound_hi [DIMS];
  logic [DATA_BITS-1:0]       word_store [CAPACITY];
  access_result_t             expected_results [$];
  position_t                  recent_writes [$];
  int                         mismatch_count = 0;
  bit                         calm = 1'b0;
  int                         holdoff_req = 0;

  multidim_array_store_core dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_op            (in_op),
    .in_coord_0       (in_coord_0),
    .in_coord_1       (in_coord_1),
    .in_coord_2       (in_coord_2),
    .in_write_word    (in_write_word),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_read_word    (out_read_word),
    .out_has_value    (out_has_value),
    .out_out_of_range (out_out_of_range),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Bounds register write as seen by the model
  function automatic void apply_bound(input logic [CFG_INDEX_BITS-1:0] idx, input index_t value);
    case (idx)
      REG_LOWER_0: bound_lo[0] = value;
      REG_UPPER_0: bound_hi[0] = value;
      REG_LOWER_1: bound_lo[1] = value;
      REG_UPPER_1: bound_hi[1] = value;
      REG_LOWER_2: bound_lo[2] = value;
      REG_UPPER_2: bound_hi[2] = value;
      default: ;
    endcase
  endfunction

  // Row-major flat offset; returns 0 on any fault
  function automatic bit locate_entry(input index_t c0, c1, c2, output int offset);
    int     coord [DIMS];
    longint ext;
    longint span;
    longint flat;
    coord[0] = c0;
    coord[1] = c1;
    coord[2] = c2;
    span     = 1;
    flat     = 0;
    offset   = 0;
    for (int d = 0; d < DIMS; d++) begin
      ext = longint'(bound_hi[d]) - longint'(bound_lo[d]) + 1;
      if (ext <= 0 || coord[d] < bound_lo[d] || coord[d] > bound_hi[d]) return 1'b0;
      span = span * ext;
      flat = flat * ext + (coord[d] - bound_lo[d]);
    end
    if (span > CAPACITY) return 1'b0;
    offset = int'(flat);
    return 1'b1;
  endfunction

  // Predict one access and update the model store
  function automatic access_result_t predict_access(input op_t op, input index_t c0, c1, c2,
                                                    input logic [DATA_BITS-1:0] word);
    access_result_t res;
    int             offset;
    res.read_word    = '0;
    res.has_value    = 1'b0;
    res.out_of_range = 1'b1;
    if (locate_entry(c0, c1, c2, offset)) begin
      res.out_of_range = 1'b0;
      if (op == OP_WRITE) begin
        word_store[offset] = word;
      end else begin
        res.read_word = word_store[offset];
        res.has_value = |word_store[offset];
      end
    end
    return res;
  endfunction

  // One input transaction, with an occasional idle burst ahead of it
  task automatic send_item(input op_t op, input index_t c0, c1, c2,
                           input logic [DATA_BITS-1:0] word);
    access_result_t res;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_push       <= 1'b1;
    in_op         <= op;
    in_coord_0    <= c0;
    in_coord_1    <= c1;
    in_coord_2    <= c2;
    in_write_word <= word;
    do @(posedge clk); while (in_full);
    res = predict_access(op, c0, c1, c2, word);
    expected_results.push_back(res);
    if (op == OP_WRITE && !res.out_of_range) begin
      recent_writes.push_back('{c0, c1, c2});
      if (recent_writes.size() > 32) void'(recent_writes.pop_front());
    end
    @(negedge clk);
  endtask

  // Stop sending and let every outstanding result come back
  task automatic wait_for_results();
    in_push <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Single config write; valid stays high for back-to-back writes
  task automatic write_bound(input logic [CFG_INDEX_BITS-1:0] idx, input index_t value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    apply_bound(idx, value);
    @(negedge clk);
  endtask

  task automatic set_bounds(input int lo0, hi0, lo1, hi1, lo2, hi2);
    write_bound(REG_LOWER_0, lo0);
    write_bound(REG_UPPER_0, hi0);
    write_bound(REG_LOWER_1, lo1);
    write_bound(REG_UPPER_1, hi1);
    write_bound(REG_LOWER_2, lo2);
    write_bound(REG_UPPER_2, hi2);
    cfg_valid <= 1'b0;
    recent_writes.delete();
  endtask

  // Random accesses: mostly in bounds, some one step off, some anywhere.
  // Half the reads go back to a recently written position.
  task automatic run_random_accesses(input int count);
    op_t                  op;
    index_t               c [DIMS];
    logic [DATA_BITS-1:0] word;
    int                   ext;
    int                   pick;
    int                   off_dim;
    position_t            p;
    repeat (count) begin
      op      = op_t'($urandom_range(0, 1));
      pick    = $urandom_range(0, 99);
      off_dim = $urandom_range(0, DIMS - 1);
      for (int d = 0; d < DIMS; d++) begin
        ext = bound_hi[d] - bound_lo[d] + 1;
        if (pick >= 85 || ext <= 0)
          c[d] = $urandom;
        else if (pick >= 70 && d == off_dim)
          c[d] = $urandom_range(0, 1) ? bound_hi[d] + 1 : bound_lo[d] - 1;
        else
          c[d] = bound_lo[d] + int'($urandom_range(0, ext - 1));
      end
      if (op == OP_READ && recent_writes.size() != 0 && $urandom_range(0, 1)) begin
        p    = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
        c[0] = p.c0;
        c[1] = p.c1;
        c[2] = p.c2;
      end
      case ($urandom_range(0, 9))
        0:       word = '0;
        1:       word = '1;
        default: word = $urandom;
      endcase
      send_item(op, c[0], c[1], c[2], word);
    end
  endtask

  // Corners of the reset geometry, full and zero words, never-written entry
  task automatic test_corner_cells();
    send_item(OP_WRITE, 0, 0, 0, 32'hFFFF_FFFF);
    send_item(OP_WRITE, 15, 15, 15, 32'h0000_0001);
    send_item(OP_READ, 0, 0, 0, 32'h0);
    send_item(OP_READ, 15, 15, 15, 32'h0);
    send_item(OP_READ, 3, 7, 9, 32'h1234_5678);
    send_item(OP_WRITE, 15, 15, 15, 32'h0);
    send_item(OP_READ, 15, 15, 15, 32'h0);
    send_item(OP_WRITE, 0, 15, 0, 32'hA5A5_5A5A);
    send_item(OP_READ, 0, 15, 0, 32'h0);
  endtask

  // Each dimension one step outside, coordinate extremes, faulting writes
  task automatic test_bound_faults();
    send_item(OP_READ, -1, 0, 0, 32'h0);
    send_item(OP_WRITE, 16, 0, 0, 32'hDEAD_BEEF);
    send_item(OP_READ, 0, -1, 0, 32'h0);
    send_item(OP_READ, 0, 16, 0, 32'h0);
    send_item(OP_WRITE, 0, 0, -1, 32'h5555_AAAA);
    send_item(OP_READ, 0, 0, 16, 32'h0);
    send_item(OP_READ, -32768, 32767, -32768, 32'h0);
    send_item(OP_WRITE, 32767, -32768, 32767, 32'h8000_0000);
    send_item(OP_READ, 0, 0, 0, 32'h0);
    send_item(OP_READ, 0, 15, 0, 32'h0);
  endtask

  // Reset geometry with a long result-side hold-off up front to fill the block
  task automatic test_random_default();
    holdoff_req = HOLDOFF_CYCLES;
    run_random_accesses(250);
  endtask

  // Writes to indexes beyond the register map leave the geometry alone
  task automatic test_unknown_register();
    wait_for_results();
    write_bound(REG_SPARE_6, $urandom);
    write_bound(REG_SPARE_7, $urandom);
    cfg_valid <= 1'b0;
    run_random_accesses(20);
  endtask

  task automatic test_negative_bounds();
    wait_for_results();
    set_bounds(-3, -2, -8, -5, -2, 1);
    holdoff_req = HOLDOFF_CYCLES / 2;
    run_random_accesses(150);
  endtask

  // Exactly CAPACITY entries with bounds pushed against both coordinate limits
  task automatic test_extreme_bounds();
    wait_for_results();
    set_bounds(-32768, -32765, 32736, 32767, -16, 15);
    run_random_accesses(200);
  endtask

  task automatic test_over_capacity();
    wait_for_results();
    set_bounds(0, 15, 0, 15, 0, 16);
    run_random_accesses(40);
    wait_for_results();
    set_bounds(-32768, 32767, -32768, 32767, -32768, 32767);
    run_random_accesses(40);
  endtask

  // Lower above upper in one dimension: everything faults
  task automatic test_empty_dimension();
    wait_for_results();
    set_bounds(0, 3, 32767, -32768, 0, 3);
    run_random_accesses(30);
    wait_for_results();
    set_bounds(0, 3, 0, 3, 5, 4);
    run_random_accesses(30);
  endtask

  task automatic test_single_entry();
    wait_for_results();
    set_bounds(7, 7, -1, -1, 32767, 32767);
    run_random_accesses(40);
  endtask

  // Random extents of 1..16 per dimension at random offsets
  task automatic test_random_geometries();
    int ext [DIMS];
    int lo [DIMS];
    repeat (4) begin
      for (int d = 0; d < DIMS; d++) begin
        ext[d] = $urandom_range(1, 16);
        lo[d]  = int'($urandom_range(0, 65536 - ext[d])) - 32768;
      end
      wait_for_results();
      set_bounds(lo[0], lo[0] + ext[0] - 1, lo[1], lo[1] + ext[1] - 1,
                 lo[2], lo[2] + ext[2] - 1);
      run_random_accesses(40);
    end
  endtask

  // Back to the reset geometry, no idling on either side
  task automatic test_calm_finish();
    wait_for_results();
    set_bounds(0, 15, 0, 15, 0, 15);
    calm = 1'b1;
    run_random_accesses(150);
  endtask

  // Result side: random stall bursts plus requested hold-offs
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_pop    = 1'b0;
    forever begin
      @(negedge clk);
      if (holdoff_req > 0) begin
        stall_left  = holdoff_req;
        holdoff_req = 0;
      end
      if (stall_left > 0) begin
        out_pop <= 1'b0;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_pop    <= 1'b0;
        stall_left = $urandom_range(0, 4);
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // Compare each popped transaction with the oldest prediction
  always @(posedge clk) begin : result_check
    access_result_t want;
    if (rst_n && out_pop && !out_empty) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: read_word %h", out_read_word);
        mismatch_count++;
      end else begin
        want = expected_results.pop_front();
        if (out_read_word !== want.read_word) begin
          $error("read_word: expected %h, actual %h", want.read_word, out_read_word);
          mismatch_count++;
        end
        if (out_has_value !== want.has_value) begin
          $error("has_value: expected %b, actual %b", want.has_value, out_has_value);
          mismatch_count++;
        end
        if (out_out_of_range !== want.out_of_range) begin
          $error("out_of_range: expected %b, actual %b", want.out_of_range, out_out_of_range);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : stimulus
    rst_n         = 1'b0;
    in_push       = 1'b0;
    in_op         = OP_WRITE;
    in_coord_0    = '0;
    in_coord_1    = '0;
    in_coord_2    = '0;
    in_write_word = '0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_LOWER_0;
    cfg_data      = '0;
    for (int d = 0; d < DIMS; d++) begin
      bound_lo[d] = 0;
      bound_hi[d] = 15;
    end
    foreach (word_store[i]) word_store[i] = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_corner_cells();
    test_bound_faults();
    test_random_default();
    test_unknown_register();
    test_negative_bounds();
    test_extreme_bounds();
    test_over_capacity();
    test_empty_dimension();
    test_single_entry();
    test_random_geometries();
    test_calm_finish();
    wait_for_results();

    if (mismatch_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

  // Hang guard
  initial begin : watchdog
    #TIMEOUT_NS;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
